[rtl/slt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants of the smoothed level trend classifier
// Register map, class codes, configuration record and per-request flags.
// ----------------------------------------------------------------------------
package slt_pkg;

    // Register indexes (byte address = 4 * index)
    localparam int          REG_ADDR_BITS = 4;
    localparam logic [1:0]  REG_WINDOW    = 2'd0;
    localparam logic [1:0]  REG_ALERT     = 2'd1;
    localparam logic [1:0]  REG_REST      = 2'd2;
    localparam logic [1:0]  REG_JUMP      = 2'd3;

    // Register reset values
    localparam logic [3:0]         WINDOW_RESET = 4'd5;
    localparam logic signed [15:0] ALERT_RESET  = 16'sd70;
    localparam logic signed [15:0] REST_RESET   = 16'sd30;
    localparam logic [15:0]        JUMP_RESET   = 16'd1;

    // Level class codes
    localparam logic [1:0] LEVEL_NORMAL = 2'd0;
    localparam logic [1:0] LEVEL_ALERT  = 2'd1;
    localparam logic [1:0] LEVEL_REST   = 2'd2;

    // Trend class codes
    localparam logic [1:0] TREND_NONE = 2'd0;
    localparam logic [1:0] TREND_RISE = 2'd1;
    localparam logic [1:0] TREND_FALL = 2'd2;

    // Quotient bits resolved per divider cycle
    localparam int DIV_RADIX_BITS = 8;

    typedef struct packed {
        logic [3:0]         window_length;
        logic signed [15:0] alert_level;
        logic signed [15:0] rest_level;
        logic [15:0]        jump_level;
    } cfg_t;

    typedef struct packed {
        logic first;   // first request of a record
        logic last;    // last request of a record
    } item_flags_t;

endpackage
`default_nettype wire

[rtl/slt_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slt_front: history ring and window accumulator
// Accepts a sample request, stores it in the ring and sums the most recent
// n samples of the record, one ring entry per cycle, then hands the sum on.
// ----------------------------------------------------------------------------
module slt_front #(
    parameter int MAX_WINDOW  = 8,
    parameter int SAMPLE_BITS = 16,
    parameter int PTR_W       = $clog2(MAX_WINDOW),
    parameter int CNT_W       = $clog2(MAX_WINDOW + 1),
    parameter int SUM_W       = SAMPLE_BITS + $clog2(MAX_WINDOW)
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  slt_pkg::cfg_t              cfg,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire [SAMPLE_BITS-1:0]      in_sample,
    input  wire                        in_last,
    output logic                       push_valid,
    input  wire                        push_ready,
    output logic signed [SUM_W-1:0]    push_sum,
    output logic [CNT_W-1:0]           push_count,
    output slt_pkg::item_flags_t       push_flags
);
    import slt_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_SUM  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t             state_reg, state_next;
    logic [SAMPLE_BITS-1:0]   ring_reg [MAX_WINDOW];
    logic [PTR_W-1:0]         wp_reg, wp_next;
    logic [PTR_W-1:0]         rd_reg, rd_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic signed [SUM_W-1:0]  acc_reg, acc_next;
    item_flags_t              flags_reg, flags_next;

    logic [CNT_W-1:0]         win;
    logic [CNT_W-1:0]         fill_inc;
    logic [CNT_W-1:0]         n_cur;
    logic                     accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == F_IDLE);

    // clamp the window to 1..MAX_WINDOW
    always_comb
    begin
        if (cfg.window_length == 4'd0)
        begin
            win = CNT_W'(1);
        end
        else if (int'(cfg.window_length) > MAX_WINDOW)
        begin
            win = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            win = CNT_W'(cfg.window_length);
        end
    end

    assign fill_inc = (fill_reg < CNT_W'(MAX_WINDOW)) ? fill_reg + CNT_W'(1) : fill_reg;
    assign n_cur    = (fill_inc < win) ? fill_inc : win;

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        rd_next    = rd_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        acc_next   = acc_reg;
        flags_next = flags_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    rd_next          = wp_reg;
                    wp_next          = (in_last || wp_reg == PTR_W'(MAX_WINDOW - 1)) ?
                                       '0 : wp_reg + PTR_W'(1);
                    fill_next        = in_last ? '0 : fill_inc;
                    cnt_next         = n_cur;
                    n_next           = n_cur;
                    acc_next         = '0;
                    flags_next.first = (fill_reg == '0);
                    flags_next.last  = in_last;
                    state_next       = F_SUM;
                end
            end
            F_SUM:
            begin
                // walk back from the newest entry
                acc_next = acc_reg + SUM_W'($signed(ring_reg[rd_reg]));
                rd_next  = (rd_reg == '0) ? PTR_W'(MAX_WINDOW - 1) : rd_reg - PTR_W'(1);
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            wp_reg    <= '0;
            rd_reg    <= '0;
            fill_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rd_reg    <= rd_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        acc_reg   <= acc_next;
        flags_reg <= flags_next;
        if (accept)
        begin
            ring_reg[wp_reg] <= in_sample;
        end
    end

    assign push_valid = (state_reg == F_PUSH);
    assign push_sum   = acc_reg;
    assign push_count = n_reg;
    assign push_flags = flags_reg;

endmodule
`default_nettype wire

[rtl/slt_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slt_queue: two-entry request queue
// Decouples the accumulator from the divider and classifier.
// ----------------------------------------------------------------------------
module slt_queue #(
    parameter int WIDTH = 8
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  wire [WIDTH-1:0]  in_data,
    output logic             out_valid,
    input  wire              out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_reg, wr_next;
    logic             rd_reg, rd_next;
    logic [1:0]       count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_next    = push ? ~wr_reg : wr_reg;
        rd_next    = pop ? ~rd_reg : rd_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_data;
        end
    end

endmodule
`default_nettype wire

[rtl/slt_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slt_back: divider, slope and classifier
// Divides the window sum by the sample count (truncating toward zero),
// forms the slope against the previous average and classes the result.
// ----------------------------------------------------------------------------
module slt_back #(
    parameter int MAX_WINDOW  = 8,
    parameter int SAMPLE_BITS = 16,
    parameter int CNT_W       = $clog2(MAX_WINDOW + 1),
    parameter int SUM_W       = SAMPLE_BITS + $clog2(MAX_WINDOW)
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  slt_pkg::cfg_t                cfg,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire signed [SUM_W-1:0]       in_sum,
    input  wire [CNT_W-1:0]              in_count,
    input  slt_pkg::item_flags_t         in_flags,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_smoothed,
    output logic signed [SAMPLE_BITS:0]  out_slope,
    output logic [1:0]                   out_level,
    output logic [1:0]                   out_trend,
    output logic                         out_report,
    output logic                         out_last
);
    import slt_pkg::*;

    localparam int RB    = DIV_RADIX_BITS;
    localparam int STEPS = (SUM_W + RB - 1) / RB;
    localparam int DW    = STEPS * RB;
    localparam int STW   = $clog2(STEPS + 1);
    localparam int LW    = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam int CW    = (SAMPLE_BITS + 2 > 18) ? SAMPLE_BITS + 2 : 18;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_DONE = 3'b100
    } back_state_t;

    back_state_t                  state_reg, state_next;
    logic [DW-1:0]                quo_reg, quo_next;
    logic [CNT_W:0]               rem_reg, rem_next;
    logic [CNT_W-1:0]             div_reg;
    logic                         neg_reg;
    logic [STW-1:0]               steps_reg, steps_next;
    item_flags_t                  flags_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg;
    logic                         out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] smoothed_reg;
    logic signed [SAMPLE_BITS:0]  slope_reg;
    logic [1:0]                   level_reg;
    logic [1:0]                   trend_reg;
    logic                         report_reg;
    logic                         last_reg;

    logic                         load;
    logic                         emit;
    logic [SUM_W-1:0]             mag;
    logic [DW-1:0]                q_step;
    logic [CNT_W:0]               r_step;
    logic [SAMPLE_BITS-1:0]       q_mag;
    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic signed [SAMPLE_BITS:0]  slope;
    logic signed [LW-1:0]         sm_w;
    logic signed [CW-1:0]         slope_w;
    logic signed [CW-1:0]         jump_w;
    logic [1:0]                   level;
    logic [1:0]                   trend;

    assign in_ready = (state_reg == B_IDLE);
    assign load     = in_valid && in_ready;
    assign emit     = (state_reg == B_DONE) && (!out_valid_reg || out_ready);
    assign mag      = in_sum[SUM_W-1] ? (~in_sum + SUM_W'(1)) : in_sum;

    // restoring division, RB quotient bits per cycle
    always_comb
    begin
        r_step = rem_reg;
        q_step = quo_reg;
        for (int j = 0; j < RB; j++)
        begin
            r_step = {r_step[CNT_W-1:0], q_step[DW-1]};
            q_step = {q_step[DW-2:0], 1'b0};
            if (r_step >= {1'b0, div_reg})
            begin
                r_step    = r_step - {1'b0, div_reg};
                q_step[0] = 1'b1;
            end
        end
    end

    always_comb
    begin
        q_mag    = quo_reg[SAMPLE_BITS-1:0];
        smoothed = neg_reg ? $signed(~q_mag + SAMPLE_BITS'(1)) : $signed(q_mag);
        slope    = flags_reg.first ? '0 :
                   (SAMPLE_BITS+1)'(smoothed) - (SAMPLE_BITS+1)'(prev_reg);
        sm_w     = LW'(smoothed);
        slope_w  = CW'(slope);
        jump_w   = CW'($signed({1'b0, cfg.jump_level}));

        priority if (sm_w > LW'(cfg.alert_level))
        begin
            level = LEVEL_ALERT;
        end
        else if (sm_w < LW'(cfg.rest_level))
        begin
            level = LEVEL_REST;
        end
        else
        begin
            level = LEVEL_NORMAL;
        end

        priority if (slope_w > jump_w)
        begin
            trend = TREND_RISE;
        end
        else if (slope_w < -jump_w)
        begin
            trend = TREND_FALL;
        end
        else
        begin
            trend = TREND_NONE;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        steps_next = steps_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (load)
                begin
                    quo_next   = DW'(mag);
                    rem_next   = '0;
                    steps_next = STW'(STEPS);
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                quo_next   = q_step;
                rem_next   = r_step;
                steps_next = steps_reg - STW'(1);
                if (steps_reg == STW'(1))
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (emit)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            steps_reg     <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            steps_reg <= steps_next;
            if (emit)
            begin
                // drop the history at record end
                prev_reg      <= flags_reg.last ? '0 : smoothed;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (load)
        begin
            div_reg   <= in_count;
            neg_reg   <= in_sum[SUM_W-1];
            flags_reg <= in_flags;
        end
        if (emit)
        begin
            smoothed_reg <= smoothed;
            slope_reg    <= slope;
            level_reg    <= level;
            trend_reg    <= trend;
            report_reg   <= (level != LEVEL_NORMAL) || (trend != TREND_NONE);
            last_reg     <= flags_reg.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_smoothed = smoothed_reg;
    assign out_slope    = slope_reg;
    assign out_level    = level_reg;
    assign out_trend    = trend_reg;
    assign out_report   = report_reg;
    assign out_last     = last_reg;

endmodule
`default_nettype wire

[rtl/smoothed_level_trend_classifier_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smoothed_level_trend_classifier_top: moving average with level and trend
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   s_*     | s_tvalid / s_tready    | s_tdata sample, s_tlast record end
//   m_*     | m_tvalid / m_tready    | m_tdata smoothed+slope, m_tuser
//           |                        | level/trend/report, m_tlast
//   apb     | psel, penable, pready  | paddr, pwdata, prdata
//
// The accumulator reads one ring entry per cycle for the n most recent samples,
// n being the active window (1 to MAX_WINDOW). The accumulator and the divider
// each take one request at a time; the two run concurrently through a two-entry
// queue, so the accumulator can take a new request while the divider works on
// the previous one. Reset is asynchronous; the ring needs no clearing. A stalled
// output holds the divider, then the queue, then s_tready.
// ----------------------------------------------------------------------------
module smoothed_level_trend_classifier_top #(
    parameter int MAX_WINDOW  = 8,
    parameter int SAMPLE_BITS = 16,
    localparam int IN_W       = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((2 * SAMPLE_BITS + 1 + 7) / 8) * 8
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [IN_W-1:0]                   s_tdata,  // sample_value
    input  wire                              s_tlast,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [OUT_W-1:0]                 m_tdata,  // smoothed_value, slope_value
    output logic [4:0]                       m_tuser,  // level_class, trend_class, report_flag
    output logic                             m_tlast,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [slt_pkg::REG_ADDR_BITS-1:0] paddr,
    input  wire [31:0]                       pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import slt_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int FLG_W = $bits(item_flags_t);
    localparam int Q_W   = SUM_W + CNT_W + FLG_W;

    cfg_t                          cfg_reg;
    logic [1:0]                    reg_idx;
    logic                          cfg_write;

    logic                          f_valid;
    logic                          f_ready;
    logic signed [SUM_W-1:0]       f_sum;
    logic [CNT_W-1:0]              f_count;
    item_flags_t                   f_flags;

    logic                          q_valid;
    logic                          q_ready;
    logic [Q_W-1:0]                q_data;

    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic signed [SAMPLE_BITS:0]   slope;
    logic [1:0]                    level;
    logic [1:0]                    trend;
    logic                          report;

    // configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length <= WINDOW_RESET;
            cfg_reg.alert_level   <= ALERT_RESET;
            cfg_reg.rest_level    <= REST_RESET;
            cfg_reg.jump_level    <= JUMP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_WINDOW: cfg_reg.window_length <= pwdata[3:0];
                REG_ALERT:  cfg_reg.alert_level   <= $signed(pwdata[15:0]);
                REG_REST:   cfg_reg.rest_level    <= $signed(pwdata[15:0]);
                REG_JUMP:   cfg_reg.jump_level    <= pwdata[15:0];
                default:    cfg_reg.window_length <= cfg_reg.window_length;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_WINDOW: prdata = 32'(cfg_reg.window_length);
            REG_ALERT:  prdata = 32'(cfg_reg.alert_level);
            REG_REST:   prdata = 32'(cfg_reg.rest_level);
            REG_JUMP:   prdata = 32'(cfg_reg.jump_level);
            default:    prdata = '0;
        endcase
    end

    slt_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .in_last    (s_tlast),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_sum   (f_sum),
        .push_count (f_count),
        .push_flags (f_flags)
    );

    slt_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_flags, f_count, f_sum}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    slt_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (q_valid),
        .in_ready     (q_ready),
        .in_sum       ($signed(q_data[SUM_W-1:0])),
        .in_count     (q_data[SUM_W +: CNT_W]),
        .in_flags     (item_flags_t'(q_data[Q_W-1 -: FLG_W])),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_smoothed (smoothed),
        .out_slope    (slope),
        .out_level    (level),
        .out_trend    (trend),
        .out_report   (report),
        .out_last     (m_tlast)
    );

    assign m_tdata = OUT_W'({slope, smoothed});
    assign m_tuser = {report, trend, level};

endmodule
`default_nettype wire
